>>> design/fvpim_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the four-vector pair invariant mass unit.
package fvpim_pkg;

  localparam int CHARGE_W     = 4;
  localparam int CHARGE_OUT_W = CHARGE_W + 1;

  typedef logic [CHARGE_W-1:0]     charge_t;
  typedef logic [CHARGE_OUT_W-1:0] charge_out_t;

  localparam logic OP_SUM  = 1'b0;
  localparam logic OP_DIFF = 1'b1;

endpackage

>>> design/fvpim_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pair input and the mass result.
interface fvpim_in_if #(
  parameter int W = 24
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [W-1:0]          px_a;
  logic [W-1:0]          py_a;
  logic [W-1:0]          pz_a;
  logic [W-1:0]          energy_a;
  fvpim_pkg::charge_t    charge_a;
  logic [W-1:0]          px_b;
  logic [W-1:0]          py_b;
  logic [W-1:0]          pz_b;
  logic [W-1:0]          energy_b;
  fvpim_pkg::charge_t    charge_b;

  modport source (
    output valid, opcode, px_a, py_a, pz_a, energy_a, charge_a,
           px_b, py_b, pz_b, energy_b, charge_b,
    input  ready
  );
  modport sink (
    input  valid, opcode, px_a, py_a, pz_a, energy_a, charge_a,
           px_b, py_b, pz_b, energy_b, charge_b,
    output ready
  );
endinterface

interface fvpim_out_if #(
  parameter int W = 24
);
  logic                    valid;
  logic                    ready;
  logic [W:0]              px_out;
  logic [W:0]              py_out;
  logic [W:0]              pz_out;
  logic [W:0]              energy_out;
  logic [W:0]              mass_out;
  logic                    mass_clamped;
  fvpim_pkg::charge_out_t  charge_out;

  modport source (
    output valid, px_out, py_out, pz_out, energy_out, mass_out, mass_clamped, charge_out,
    input  ready
  );
  modport sink (
    input  valid, px_out, py_out, pz_out, energy_out, mass_out, mass_clamped, charge_out,
    output ready
  );
endinterface

>>> design/fvpim_front.sv
`timescale 1ns / 1ps
// Front pipeline: combine the vectors, square the components and form the radicand.
module fvpim_front #(
  parameter int W      = 24,
  parameter int SIDE_W = 4 * (W + 1) + fvpim_pkg::CHARGE_OUT_W + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  fvpim_in_if.sink            in_ch,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2*W+1:0]      rad_out,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int CW   = W + 1;
  localparam int SQW  = 2 * W + 1;
  localparam int P2W  = 2 * W + 2;
  localparam int RADW = 2 * W + 2;
  localparam int DW   = 2 * W + 3;
  localparam int QW   = fvpim_pkg::CHARGE_OUT_W;

  logic [W-1:0]  a_in [4];
  logic [W-1:0]  b_in [4];

  logic          v1_r, v2_r, v3_r, v4_r;
  logic          rdy1, rdy2, rdy3, rdy4;

  logic [CW-1:0] c1_nxt [4];
  logic [CW-1:0] c1_r   [4];
  logic [QW-1:0] q1_nxt;
  logic [QW-1:0] q1_r;

  logic [CW-1:0] mag    [4];
  logic [SQW-1:0] sq2_nxt [4];
  logic [SQW-1:0] sq2_r   [4];
  logic [CW-1:0] c2_r   [4];
  logic [QW-1:0] q2_r;

  logic [SQW-1:0] e2_r;
  logic [P2W-1:0] p2_nxt;
  logic [P2W-1:0] p2_r;
  logic [CW-1:0] c3_r   [4];
  logic [QW-1:0] q3_r;

  logic [DW-1:0]  diff;
  logic           clamp;
  logic [RADW-1:0] rad_r;
  logic [SIDE_W-1:0] side_r;

  assign a_in[0] = in_ch.px_a;
  assign a_in[1] = in_ch.py_a;
  assign a_in[2] = in_ch.pz_a;
  assign a_in[3] = in_ch.energy_a;
  assign b_in[0] = in_ch.px_b;
  assign b_in[1] = in_ch.py_b;
  assign b_in[2] = in_ch.pz_b;
  assign b_in[3] = in_ch.energy_b;

  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (in_ch.opcode == fvpim_pkg::OP_DIFF) begin
        c1_nxt[k] = {a_in[k][W-1], a_in[k]} - {b_in[k][W-1], b_in[k]};
      end else begin
        c1_nxt[k] = {a_in[k][W-1], a_in[k]} + {b_in[k][W-1], b_in[k]};
      end
    end
    if (in_ch.opcode == fvpim_pkg::OP_DIFF) begin
      q1_nxt = {in_ch.charge_a[fvpim_pkg::CHARGE_W-1], in_ch.charge_a};
    end else begin
      q1_nxt = {in_ch.charge_a[fvpim_pkg::CHARGE_W-1], in_ch.charge_a}
             + {in_ch.charge_b[fvpim_pkg::CHARGE_W-1], in_ch.charge_b};
    end
  end

  always_comb begin
    logic [2*CW-1:0] prod;
    for (int k = 0; k < 4; k++) begin
      mag[k]     = c1_r[k][CW-1] ? (~c1_r[k] + 1'b1) : c1_r[k];
      prod       = mag[k] * mag[k];
      sq2_nxt[k] = prod[SQW-1:0];
    end
  end

  assign p2_nxt = {1'b0, sq2_r[0]} + {1'b0, sq2_r[1]} + {1'b0, sq2_r[2]};

  assign diff  = {2'b00, e2_r} - {1'b0, p2_r};
  assign clamp = diff[DW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      c1_r <= c1_nxt;
      q1_r <= q1_nxt;
    end
    if (rdy2 && v1_r) begin
      sq2_r <= sq2_nxt;
      c2_r  <= c1_r;
      q2_r  <= q1_r;
    end
    if (rdy3 && v2_r) begin
      e2_r <= sq2_r[3];
      p2_r <= p2_nxt;
      c3_r <= c2_r;
      q3_r <= q2_r;
    end
    if (rdy4 && v3_r) begin
      rad_r  <= clamp ? '0 : diff[RADW-1:0];
      side_r <= {c3_r[0], c3_r[1], c3_r[2], c3_r[3], q3_r, clamp};
    end
  end

  assign out_valid = v4_r;
  assign rad_out   = rad_r;
  assign side_out  = side_r;

endmodule

>>> design/fvpim_sqrt_cell.sv
`timescale 1ns / 1ps
// One square root cell: retires one root bit and passes its state to the next cell.
module fvpim_sqrt_cell #(
  parameter int W      = 24,
  parameter int SIDE_W = 4 * (W + 1) + fvpim_pkg::CHARGE_OUT_W + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [W+3:0]        rem_in,
  input  logic [W:0]          root_in,
  input  logic [2*W+1:0]      rad_in,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [W+3:0]        rem_out,
  output logic [W:0]          root_out,
  output logic [2*W+1:0]      rad_out,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int RW   = W + 4;
  localparam int RADW = 2 * W + 2;

  logic              valid_r;
  logic [RW-1:0]     rem_r;
  logic [W:0]        root_r;
  logic [RADW-1:0]   rad_r;
  logic [SIDE_W-1:0] side_r;

  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;
  logic              fits;
  logic [RW-1:0]     rem_nxt;
  logic [W:0]        root_nxt;

  assign rem_sh   = {rem_in[RW-3:0], rad_in[RADW-1:RADW-2]};
  assign trial    = {1'b0, root_in, 2'b01};
  assign fits     = rem_sh >= trial;
  assign rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_in[W-1:0], fits};

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= {rad_in[RADW-3:0], 2'b00};
      side_r <= side_in;
    end
  end

  assign out_valid = valid_r;
  assign rem_out   = rem_r;
  assign root_out  = root_r;
  assign rad_out   = rad_r;
  assign side_out  = side_r;

endmodule

>>> design/four_vector_pair_invariant_mass_unit.sv
`timescale 1ns / 1ps
// Top level of the four-vector pair invariant mass unit.
//
// The in_ch channel carries one particle pair per transfer with an opcode that
// selects sum or difference; the out_ch channel returns the combined four-vector,
// the combined charge (charge_a alone for difference), the floor square root
// mass and the clamp flag. Both channels transfer when valid and ready are high
// at a rising clock edge. Four front stages form the combined vector, the
// squares, the momentum sum and the radicand, then a row of COMPONENT_WIDTH + 1
// square root cells retires one root bit each. Throughput is one transfer per
// cycle while out_ch accepts; every stage has its own valid bit, so a new pair
// enters while earlier pairs are still in the row.
// When out_ch stalls, the result holds in the last cell and stages behind it fill
// up; empty stages keep accepting until the row is full, then in_ch.ready drops.
// Synchronous reset clears all valid bits; no result is lost or repeated.
module four_vector_pair_invariant_mass_unit #(
  parameter int COMPONENT_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  fvpim_in_if.sink    in_ch,
  fvpim_out_if.source out_ch
);

  localparam int W      = COMPONENT_WIDTH;
  localparam int CW     = W + 1;
  localparam int QW     = fvpim_pkg::CHARGE_OUT_W;
  localparam int SIDE_W = 4 * CW + QW + 1;
  localparam int NCELL  = W + 1;

  logic              v_c    [NCELL+1];
  logic              rdy_c  [NCELL+1];
  logic [W+3:0]      rem_c  [NCELL+1];
  logic [W:0]        root_c [NCELL+1];
  logic [2*W+1:0]    rad_c  [NCELL+1];
  logic [SIDE_W-1:0] side_c [NCELL+1];

  fvpim_front #(
    .W      (W),
    .SIDE_W (SIDE_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_valid (v_c[0]),
    .out_ready (rdy_c[0]),
    .rad_out   (rad_c[0]),
    .side_out  (side_c[0])
  );

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fvpim_sqrt_cell #(
      .W      (W),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_c[i]),
      .in_ready  (rdy_c[i]),
      .rem_in    (rem_c[i]),
      .root_in   (root_c[i]),
      .rad_in    (rad_c[i]),
      .side_in   (side_c[i]),
      .out_valid (v_c[i+1]),
      .out_ready (rdy_c[i+1]),
      .rem_out   (rem_c[i+1]),
      .root_out  (root_c[i+1]),
      .rad_out   (rad_c[i+1]),
      .side_out  (side_c[i+1])
    );
  end

  assign rdy_c[NCELL] = out_ch.ready;

  assign out_ch.valid        = v_c[NCELL];
  assign out_ch.px_out       = side_c[NCELL][SIDE_W-1 -: CW];
  assign out_ch.py_out       = side_c[NCELL][SIDE_W-1-CW -: CW];
  assign out_ch.pz_out       = side_c[NCELL][SIDE_W-1-2*CW -: CW];
  assign out_ch.energy_out   = side_c[NCELL][SIDE_W-1-3*CW -: CW];
  assign out_ch.charge_out   = side_c[NCELL][QW:1];
  assign out_ch.mass_clamped = side_c[NCELL][0];
  assign out_ch.mass_out     = root_c[NCELL];

endmodule
